FILE: design/bvrs_pkg.sv
// shared types and constants for the rank/select bit vector
`timescale 1ns / 1ps
`default_nettype none
package bvrs_pkg;
	localparam int WordBits = 64;
	localparam int OffW = 6;

	typedef enum logic [2:0] {
		MODE_CLEAR   = 3'd0,
		MODE_APPEND  = 3'd1,
		MODE_ACCESS  = 3'd2,
		MODE_RANK1   = 3'd3,
		MODE_RANK0   = 3'd4,
		MODE_SELECT1 = 3'd5,
		MODE_SELECT0 = 3'd6,
		MODE_BAD     = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RANGE    = 3'd1,
		ST_MISS     = 3'd2,
		ST_BADBIT   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_WAIT,
		S_EXEC,
		S_PROBE,
		S_PWAIT,
		S_PCMP,
		S_WREAD,
		S_WWAIT,
		S_SCAN,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: design/bvrs_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps
`default_nettype none
interface bvrs_in_if #(parameter int PosW = 13);
	logic            valid;
	logic            ready;
	logic [2:0]      mode;
	logic [7:0]      bit_value;
	logic [PosW-1:0] position;
	modport source(output valid, mode, bit_value, position, input ready);
	modport sink(input valid, mode, bit_value, position, output ready);
endinterface

interface bvrs_out_if #(parameter int PosW = 13);
	logic            valid;
	logic            ready;
	logic [PosW-1:0] value;
	logic [2:0]      status;
	logic [PosW-1:0] total_bits;
	logic [PosW-1:0] total_ones;
	modport source(output valid, value, status, total_bits, total_ones, input ready);
	modport sink(input valid, value, status, total_bits, total_ones, output ready);
endinterface
`default_nettype wire

FILE: design/bvrs_pop.sv
// popcount of the masked word low bits and k-th set bit search, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bvrs_pop (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [63:0]              word,
	input  wire logic [6:0]               limit,
	input  wire logic [6:0]               k,
	output logic                          busy,
	output logic [6:0]                    count,
	output logic [6:0]                    found
);
	logic [63:0] word_q;
	logic [6:0]  idx_q;
	logic [6:0]  limit_q;
	logic [6:0]  k_q;
	logic [6:0]  count_q;
	logic [6:0]  found_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && idx_q == 7'd63) begin
			busy_q <= 1'b0;
		end
	end

	// one bit per cycle: count ones below limit, note k-th one
	always_ff @(posedge clk) begin
		if (start) begin
			word_q  <= word;
			idx_q   <= '0;
			limit_q <= limit;
			k_q     <= k;
			count_q <= '0;
			found_q <= 7'd64;
		end else if (busy_q) begin
			if (word_q[idx_q[5:0]] && idx_q < limit_q) begin
				if (count_q == k_q && found_q == 7'd64)
					found_q <= idx_q;
				count_q <= count_q + 7'd1;
			end
			idx_q <= idx_q + 7'd1;
		end
	end

	assign busy  = busy_q;
	assign count = count_q;
	assign found = found_q;
endmodule
`default_nettype wire

FILE: design/bit_vector_rank_select_top.sv
// rank/select bit vector: 64 words of 64 bits and a table of ones before each word
// clear, append, access and mode 7 run without the scan unit; rank runs one in-word scan;
// select runs a binary search of up to seven count table probes, then the in-word scan, one item at a time
// throughput is set by the bit-serial scan unit shared by rank and select
// reset clears the length and ones count; count table entry 0 always reads as zero
// a clear item sweeps the count table, one entry a cycle
`timescale 1ns / 1ps
`default_nettype none
module bit_vector_rank_select_top (
	input  wire logic clk,
	input  wire logic arst_n,
	bvrs_in_if.sink   in_ch,
	bvrs_out_if.source out_ch
);
	localparam int PosW = 13;
	localparam int NW = 64;
	localparam logic [PosW-1:0] MaxBits = 13'd4096;

	logic [63:0]     words_mem [NW];
	logic [PosW-1:0] obw_mem [NW+1];
	logic [63:0]     wrd_rd_q;
	logic [PosW-1:0] obw_rd_q;

	bvrs_pkg::state_t state_q, state_d;
	logic [2:0]      mode_q;
	logic [7:0]      bv_q;
	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] len_q;
	logic [PosW-1:0] tones_q;
	logic [6:0]      lo_q, hi_q;
	logic [6:0]      sweep_q;
	logic [6:0]      w_q;
	logic [PosW-1:0] base_q;
	logic [PosW-1:0] value_q;
	logic [2:0]      status_q;
	logic            ovalid_q;

	logic [6:0] used_words;
	logic [6:0] mid;
	logic [6:0] pc_count, pc_found;
	logic       pc_busy, pc_start;
	logic [63:0] pc_word;
	logic [6:0]  pc_limit, pc_k;
	logic        ones_sel;
	logic [6:0]  obw_addr;
	logic [5:0]  wrd_addr;
	logic [PosW-1:0] zb_at_w;

	assign used_words = len_q[12:6] + {6'd0, |len_q[5:0]};
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign ones_sel = (mode_q == bvrs_pkg::MODE_SELECT1);

	always_comb begin
		obw_addr = pos_q[12:6];
		wrd_addr = pos_q[11:6];
		case (state_q)
			bvrs_pkg::S_PROBE, bvrs_pkg::S_PWAIT: obw_addr = mid + 7'd1;
			bvrs_pkg::S_WREAD: begin obw_addr = w_q; wrd_addr = w_q[5:0]; end
			default: begin
				if (mode_q == bvrs_pkg::MODE_APPEND) begin
					obw_addr = len_q[12:6];
					wrd_addr = len_q[11:6];
				end
			end
		endcase
	end

	// zeros-before for word boundary w given the ones count there
	function automatic logic [PosW-1:0] zb(input logic [6:0] w, input logic [PosW-1:0] ones,
			input logic [PosW-1:0] len, input logic [6:0] uw);
		logic [PosW-1:0] bound;
		bound = (w == uw) ? len : {w[6:0], 6'd0};
		return bound - ones;
	endfunction

	assign zb_at_w = zb(w_q, obw_rd_q, len_q, used_words);

	always_ff @(posedge clk) begin
		obw_rd_q <= (obw_addr == 7'd0) ? '0 : obw_mem[obw_addr];
		wrd_rd_q <= words_mem[wrd_addr];
		if (state_q == bvrs_pkg::S_CLEAR)
			obw_mem[sweep_q] <= '0;
		if (state_q == bvrs_pkg::S_EXEC && mode_q == bvrs_pkg::MODE_APPEND &&
				bv_q <= 8'd1 && len_q < MaxBits) begin
			if (len_q[5:0] == 6'd0) begin
				words_mem[len_q[11:6]] <= {63'd0, bv_q[0]};
				obw_mem[len_q[12:6] + 7'd1] <= obw_rd_q + {12'd0, bv_q[0]};
			end else begin
				words_mem[len_q[11:6]] <= wrd_rd_q | ({63'd0, bv_q[0]} << len_q[5:0]);
				obw_mem[len_q[12:6] + 7'd1] <= tones_q + {12'd0, bv_q[0]};
			end
		end
	end

	always_comb begin
		pc_start = 1'b0;
		pc_word  = wrd_rd_q;
		pc_limit = 7'd64;
		pc_k     = 7'd127;
		if (state_q == bvrs_pkg::S_EXEC &&
				(mode_q == bvrs_pkg::MODE_RANK1 || mode_q == bvrs_pkg::MODE_RANK0) &&
				pos_q <= len_q) begin
			pc_start = 1'b1;
			pc_limit = {1'b0, pos_q[5:0]};
		end else if (state_q == bvrs_pkg::S_WWAIT) begin
			pc_start = 1'b1;
			if (ones_sel) begin
				pc_k = pos_q[6:0] - obw_rd_q[6:0];
			end else begin
				pc_word = ~wrd_rd_q;
				pc_k = pos_q[6:0] - zb_at_w[6:0];
				if (w_q + 7'd1 >= used_words && len_q[5:0] != 6'd0)
					pc_limit = {1'b0, len_q[5:0]};
			end
		end
	end

	bvrs_pop u_pop (
		.clk(clk), .arst_n(arst_n), .start(pc_start), .word(pc_word),
		.limit(pc_limit), .k(pc_k), .busy(pc_busy), .count(pc_count), .found(pc_found)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bvrs_pkg::S_IDLE:  if (in_ch.valid && !ovalid_q) state_d = bvrs_pkg::S_READ;
			bvrs_pkg::S_READ:  state_d = (mode_q == bvrs_pkg::MODE_CLEAR) ?
					bvrs_pkg::S_CLEAR : bvrs_pkg::S_WAIT;
			bvrs_pkg::S_CLEAR: if (sweep_q == 7'd64) state_d = bvrs_pkg::S_DONE;
			bvrs_pkg::S_WAIT:  state_d = bvrs_pkg::S_EXEC;
			bvrs_pkg::S_EXEC: begin
				state_d = bvrs_pkg::S_DONE;
				if (pc_start) state_d = bvrs_pkg::S_SCAN;
				else if ((mode_q == bvrs_pkg::MODE_SELECT1 || mode_q == bvrs_pkg::MODE_SELECT0) &&
						pos_q < (ones_sel ? tones_q : len_q - tones_q))
					state_d = bvrs_pkg::S_PROBE;
			end
			bvrs_pkg::S_PROBE: state_d = (lo_q < hi_q) ? bvrs_pkg::S_PWAIT : bvrs_pkg::S_WREAD;
			bvrs_pkg::S_PWAIT: state_d = bvrs_pkg::S_PCMP;
			bvrs_pkg::S_PCMP:  state_d = bvrs_pkg::S_PROBE;
			bvrs_pkg::S_WREAD: state_d = (w_q >= 7'd64) ? bvrs_pkg::S_DONE : bvrs_pkg::S_WWAIT;
			bvrs_pkg::S_WWAIT: state_d = bvrs_pkg::S_SCAN;
			bvrs_pkg::S_SCAN:  if (!pc_busy) state_d = bvrs_pkg::S_DONE;
			bvrs_pkg::S_DONE:  state_d = bvrs_pkg::S_IDLE;
			default:           state_d = bvrs_pkg::S_IDLE;
		endcase
	end

	logic [PosW-1:0] through;
	logic [PosW-1:0] sel_pos;
	always_comb begin
		through = ones_sel ? obw_rd_q : zb(mid + 7'd1, obw_rd_q, len_q, used_words);
		sel_pos = {w_q[6:0], 6'd0} + {6'd0, pc_found};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bvrs_pkg::S_IDLE;
			len_q    <= '0;
			tones_q  <= '0;
			ovalid_q <= 1'b0;
			sweep_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				bvrs_pkg::S_IDLE: begin
					sweep_q <= '0;
					if (in_ch.valid && !ovalid_q) begin
						mode_q <= in_ch.mode; bv_q <= in_ch.bit_value; pos_q <= in_ch.position;
					end
				end
				bvrs_pkg::S_READ: begin
					value_q <= '0; status_q <= bvrs_pkg::ST_OK;
					if (mode_q == bvrs_pkg::MODE_CLEAR) begin len_q <= '0; tones_q <= '0; end
				end
				bvrs_pkg::S_CLEAR: sweep_q <= sweep_q + 7'd1;
				bvrs_pkg::S_EXEC: begin
					lo_q <= '0; hi_q <= used_words;
					case (mode_q)
						bvrs_pkg::MODE_APPEND: begin
							if (bv_q > 8'd1) status_q <= bvrs_pkg::ST_BADBIT;
							else if (len_q >= MaxBits) status_q <= bvrs_pkg::ST_FULL;
							else begin
								len_q <= len_q + 13'd1;
								tones_q <= tones_q + {12'd0, bv_q[0]};
							end
						end
						bvrs_pkg::MODE_ACCESS: begin
							if (pos_q >= len_q) status_q <= bvrs_pkg::ST_RANGE;
							else value_q <= {12'd0, wrd_rd_q[pos_q[5:0]]};
						end
						bvrs_pkg::MODE_RANK1, bvrs_pkg::MODE_RANK0: begin
							if (pos_q > len_q) status_q <= bvrs_pkg::ST_RANGE;
							base_q <= obw_rd_q;
						end
						bvrs_pkg::MODE_SELECT1, bvrs_pkg::MODE_SELECT0: begin
							if (!(pos_q < (ones_sel ? tones_q : len_q - tones_q)))
								status_q <= bvrs_pkg::ST_MISS;
						end
						default: status_q <= bvrs_pkg::ST_RANGE;
					endcase
				end
				bvrs_pkg::S_PROBE: w_q <= lo_q;
				bvrs_pkg::S_PCMP: begin
					if (through > pos_q) hi_q <= mid;
					else lo_q <= mid + 7'd1;
				end
				bvrs_pkg::S_WREAD: if (w_q >= 7'd64) status_q <= bvrs_pkg::ST_MISS;
				bvrs_pkg::S_SCAN: begin
					if (!pc_busy) begin
						if (mode_q == bvrs_pkg::MODE_RANK1)
							value_q <= base_q + {6'd0, pc_count};
						else if (mode_q == bvrs_pkg::MODE_RANK0)
							value_q <= pos_q - base_q - {6'd0, pc_count};
						else if (pc_found[6] || sel_pos >= len_q)
							status_q <= bvrs_pkg::ST_MISS;
						else
							value_q <= sel_pos;
					end
				end
				bvrs_pkg::S_DONE: ovalid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign in_ch.ready       = (state_q == bvrs_pkg::S_IDLE) && !ovalid_q;
	assign out_ch.valid      = ovalid_q;
	assign out_ch.value      = value_q;
	assign out_ch.status     = status_q;
	assign out_ch.total_bits = len_q;
	assign out_ch.total_ones = tones_q;
endmodule
`default_nettype wire
